>>> src/tsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsp_pkg
// Types, codes and constants shared by the transport stream packetizer.
// ----------------------------------------------------------------------------
package tsp_pkg;

  localparam int unsigned MaxFrameBytes = 1048576;
  localparam int unsigned CmdDepth      = 4;

  // item function codes
  localparam logic [1:0] FuncBegin = 2'd0;
  localparam logic [1:0] FuncHdr   = 2'd1;
  localparam logic [1:0] FuncEs    = 2'd2;

  // configuration
  localparam int unsigned PaddrW       = 3;
  localparam logic        RegStreamPid = 1'b0;

  // packet constants
  localparam logic [7:0] SyncByte     = 8'h47;
  localparam logic [7:0] PusiFlag     = 8'h40;
  localparam logic [7:0] ScPayload    = 8'h10;
  localparam logic [7:0] ScAfPayload  = 8'h30;
  localparam logic [7:0] AfFlagsByte  = 8'h00;
  localparam logic [7:0] FillByte     = 8'hFF;
  localparam logic [7:0] PayloadBytes = 8'd184;
  localparam logic [7:0] AdaptBase    = 8'd183;

  // run steps of one command, in output order
  localparam int unsigned NumSteps = 9;
  localparam logic [3:0] StepSync    = 4'd0;
  localparam logic [3:0] StepPidHi   = 4'd1;
  localparam logic [3:0] StepPidLo   = 4'd2;
  localparam logic [3:0] StepCc      = 4'd3;
  localparam logic [3:0] StepAfLen   = 4'd4;
  localparam logic [3:0] StepAfFlags = 4'd5;
  localparam logic [3:0] StepStuff   = 4'd6;
  localparam logic [3:0] StepData    = 4'd7;
  localparam logic [3:0] StepFill    = 4'd8;

  typedef struct packed {
    logic        hdr_en;
    logic        pusi;
    logic [3:0]  cc;
    logic        adapt_en;
    logic [7:0]  adapt;
    logic        flags_en;
    logic        stuff_en;
    logic        data_en;
    logic [7:0]  data;
    logic        fill_en;
    logic [7:0]  fill_len;
    logic        pkt_last;
    logic        frame_last;
    logic [12:0] pkt_total;
  } tsp_cmd_t;

endpackage

>>> src/tsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsp_in_if / tsp_out_if
// Valid/ready channels for input items and output byte runs.
// ----------------------------------------------------------------------------
interface tsp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [3:0]  cc_init;
  logic        with_pusi;
  logic [7:0]  header_length;
  logic [19:0] es_length;
  logic [7:0]  data_byte;

  modport source (
    output valid, func, cc_init, with_pusi, header_length, es_length, data_byte,
    input  ready
  );
  modport sink (
    input  valid, func, cc_init, with_pusi, header_length, es_length, data_byte,
    output ready
  );
endinterface

interface tsp_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic [7:0]  run_length;
  logic        packet_first;
  logic        packet_last;
  logic        frame_last;
  logic [12:0] pkt_number;

  modport source (
    output valid, out_byte, run_length, packet_first, packet_last, frame_last,
           pkt_number,
    input  ready
  );
  modport sink (
    input  valid, out_byte, run_length, packet_first, packet_last, frame_last,
           pkt_number,
    output ready
  );
endinterface

>>> src/ts_es_packetizer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ts_es_packetizer_core
// Cuts elementary-stream frames into 188-byte transport packets, output as
// runs of equal bytes with packet and frame marks.
// ----------------------------------------------------------------------------
//  channel   dir  handshake              carries
//  items_i   in   valid/ready            func, cc_init, with_pusi, lengths, byte
//  runs_o    out  valid/ready            out_byte, run_length, marks, count
//  apb       in   psel/penable/pwrite    stream_pid at word 0
//
//  Front takes one item per cycle while the command queue has room.
//  Back sends one run per cycle while runs_o is ready; an item that opens a
//  packet gives up to eight runs, a data byte one run, two if it closes with fill.
//  Reset clears all control state at once; no clearing pass.
//  Either side may stall; the queue and output register decouple them.
// ----------------------------------------------------------------------------
module ts_es_packetizer_core #(
  parameter int unsigned MAX_FRAME_BYTES = tsp_pkg::MaxFrameBytes,
  parameter int unsigned CMD_DEPTH       = tsp_pkg::CmdDepth
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  tsp_in_if.sink                     items_i,
  tsp_out_if.source                  runs_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tsp_pkg::PaddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import tsp_pkg::*;

  logic [12:0] pid_q;
  logic        cfg_wr;
  logic        push;
  logic        pop;
  logic        q_full;
  logic        q_empty;
  tsp_cmd_t    cmd_in;
  tsp_cmd_t    cmd_head;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[PaddrW-1] == RegStreamPid);
  assign prdata = (paddr[PaddrW-1] == RegStreamPid) ? {19'd0, pid_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pid_q <= '0;
    end else if (cfg_wr) begin
      pid_q <= pwdata[12:0];
    end
  end

  tsp_front #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .items_i (items_i),
    .q_full_i(q_full),
    .push_o  (push),
    .cmd_o   (cmd_in)
  );

  tsp_cmd_fifo #(
    .DEPTH(CMD_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (cmd_in),
    .full_o (q_full),
    .pop_i  (pop),
    .empty_o(q_empty),
    .data_o (cmd_head)
  );

  tsp_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .pid_i    (pid_q),
    .q_empty_i(q_empty),
    .q_head_i (cmd_head),
    .pop_o    (pop),
    .runs_o   (runs_o)
  );

endmodule

>>> src/tsp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsp_front
// Accepts items, tracks frame and packet state, and emits one run command
// per item that produces output.
// ----------------------------------------------------------------------------
module tsp_front #(
  parameter int unsigned MAX_FRAME_BYTES = tsp_pkg::MaxFrameBytes
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  tsp_in_if.sink            items_i,
  input  logic              q_full_i,
  output logic              push_o,
  output tsp_pkg::tsp_cmd_t cmd_o
);
  import tsp_pkg::*;

  localparam logic [24:0] MaxLen = 25'(MAX_FRAME_BYTES);

  logic [3:0]  cc_q, cc_d;
  logic [19:0] stream_q, stream_d;
  logic [7:0]  room_q, room_d;
  logic [7:0]  hdr_left_q, hdr_left_d;
  logic        first_open_q, first_open_d;
  logic        active_q, active_d;
  logic [12:0] pkt_total_q, pkt_total_d;

  logic        accept;
  logic        has_run;
  logic        pusi;
  logic [7:0]  hlen;
  logic [19:0] elen;
  logic [7:0]  room_open;
  logic [7:0]  room_n;
  logic [7:0]  hdr_n;
  logic [19:0] stream_n;

  assign items_i.ready = !q_full_i;
  assign accept        = items_i.valid && items_i.ready;
  assign push_o        = accept && has_run;

  always_comb begin
    cc_d         = cc_q;
    stream_d     = stream_q;
    room_d       = room_q;
    hdr_left_d   = hdr_left_q;
    first_open_d = first_open_q;
    active_d     = active_q;
    pkt_total_d  = pkt_total_q;
    has_run      = 1'b0;
    cmd_o           = '0;
    cmd_o.cc        = cc_q;
    cmd_o.pkt_total = pkt_total_q;
    cmd_o.data      = items_i.data_byte;

    hlen = (items_i.header_length > PayloadBytes) ? PayloadBytes : items_i.header_length;
    elen = ({5'd0, items_i.es_length} > MaxLen) ? MaxLen[19:0] : items_i.es_length;
    pusi = items_i.with_pusi && (hlen != 8'd0);
    room_open = room_q;
    room_n    = room_q - 8'd1;
    hdr_n     = hdr_left_q - 8'd1;
    stream_n  = stream_q - 20'd1;

    unique case (items_i.func)
      FuncBegin: begin
        stream_d     = elen;
        first_open_d = pusi;
        active_d     = pusi || (elen != 20'd0);
        hdr_left_d   = pusi ? hlen : 8'd0;
        room_d       = pusi ? PayloadBytes : 8'd0;
        pkt_total_d  = pusi ? 13'd1 : 13'd0;
        cc_d         = pusi ? items_i.cc_init + 4'd1 : items_i.cc_init;
        has_run         = pusi;
        cmd_o.hdr_en    = pusi;
        cmd_o.pusi      = 1'b1;
        cmd_o.cc        = items_i.cc_init;
        cmd_o.pkt_total = 13'd1;
      end
      FuncHdr: begin
        if (active_q && first_open_q && (hdr_left_q != 8'd0)) begin
          has_run       = 1'b1;
          cmd_o.data_en = 1'b1;
          hdr_left_d    = hdr_n;
          room_d        = room_n;
          if (hdr_n == 8'd0) begin
            if (room_n == 8'd0 || stream_q == 20'd0) begin
              cmd_o.fill_en  = (room_n != 8'd0);
              cmd_o.fill_len = room_n;
              room_d         = 8'd0;
              first_open_d   = 1'b0;
              cmd_o.pkt_last = 1'b1;
              if (stream_q == 20'd0) begin
                cmd_o.frame_last = 1'b1;
                active_d         = 1'b0;
              end
            end
          end
        end
      end
      FuncEs: begin
        if (active_q && (hdr_left_q == 8'd0) && (stream_q != 20'd0)) begin
          has_run       = 1'b1;
          cmd_o.data_en = 1'b1;
          if (!first_open_q && room_q == 8'd0) begin
            cmd_o.hdr_en    = 1'b1;
            cmd_o.pkt_total = pkt_total_q + 13'd1;
            pkt_total_d     = pkt_total_q + 13'd1;
            cc_d            = cc_q + 4'd1;
            if (stream_q >= 20'(PayloadBytes)) begin
              room_open = PayloadBytes;
            end else begin
              room_open      = stream_q[7:0];
              cmd_o.adapt_en = 1'b1;
              cmd_o.adapt    = AdaptBase - stream_q[7:0];
              cmd_o.flags_en = (cmd_o.adapt >= 8'd1);
              cmd_o.stuff_en = (cmd_o.adapt >= 8'd2);
            end
          end
          room_n   = room_open - 8'd1;
          stream_d = stream_n;
          room_d   = room_n;
          if (room_n == 8'd0 || (first_open_q && stream_n == 20'd0)) begin
            cmd_o.fill_en  = (room_n != 8'd0);
            cmd_o.fill_len = room_n;
            room_d         = 8'd0;
            first_open_d   = 1'b0;
            cmd_o.pkt_last = 1'b1;
            if (stream_n == 20'd0) begin
              cmd_o.frame_last = 1'b1;
              active_d         = 1'b0;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cc_q         <= '0;
      stream_q     <= '0;
      room_q       <= '0;
      hdr_left_q   <= '0;
      first_open_q <= 1'b0;
      active_q     <= 1'b0;
      pkt_total_q  <= '0;
    end else if (accept) begin
      cc_q         <= cc_d;
      stream_q     <= stream_d;
      room_q       <= room_d;
      hdr_left_q   <= hdr_left_d;
      first_open_q <= first_open_d;
      active_q     <= active_d;
      pkt_total_q  <= pkt_total_d;
    end
  end

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_q |-> (room_q == 8'd0) && (hdr_left_q == 8'd0) && !first_open_q)
    else $error("idle frame state not clear");

  a_first_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    first_open_q |-> (room_q != 8'd0) && (room_q >= hdr_left_q))
    else $error("first packet without room for header");

endmodule

>>> src/tsp_cmd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsp_cmd_fifo
// Short command queue between the front and the back part.
// ----------------------------------------------------------------------------
module tsp_cmd_fifo #(
  parameter int unsigned DEPTH = tsp_pkg::CmdDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  tsp_pkg::tsp_cmd_t data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output tsp_pkg::tsp_cmd_t data_o
);
  import tsp_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  tsp_cmd_t            mem_q [DEPTH];
  logic [PtrW-1:0]     wptr_q, rptr_q;
  logic [CntW-1:0]     cnt_q;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PtrW'(DEPTH - 1)) ? '0 : wptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PtrW'(DEPTH - 1)) ? '0 : rptr_q + PtrW'(1);
      end
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + CntW'(1);
        2'b01:   cnt_q <= cnt_q - CntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o) && !(pop_i && empty_o))
    else $error("command queue over- or underflow");

endmodule

>>> src/tsp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsp_back
// Expands run commands into output byte runs, one run per cycle while not
// stalled by the output, through an output register.
// ----------------------------------------------------------------------------
module tsp_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [12:0]       pid_i,
  input  logic              q_empty_i,
  input  tsp_pkg::tsp_cmd_t q_head_i,
  output logic              pop_o,
  tsp_out_if.source         runs_o
);
  import tsp_pkg::*;

  tsp_cmd_t              cur_q;
  logic [NumSteps-1:0]   mask_q;
  logic                  cur_vld_q;

  logic [NumSteps-1:0]   head_mask;
  logic [NumSteps-1:0]   rest;
  logic [3:0]            step;
  logic                  advance;
  logic                  last_run;

  logic [7:0]  byte_d, byte_q;
  logic [7:0]  len_d, len_q;
  logic        first_d, first_q;
  logic        plast_q, flast_q;
  logic [12:0] pkt_q;
  logic        out_vld_q;

  assign head_mask = {q_head_i.fill_en, q_head_i.data_en, q_head_i.stuff_en,
                      q_head_i.flags_en, q_head_i.adapt_en, {4{q_head_i.hdr_en}}};

  assign advance  = cur_vld_q && (!out_vld_q || runs_o.ready);
  assign rest     = mask_q & (mask_q - NumSteps'(1));
  assign last_run = (rest == '0);
  assign pop_o    = !q_empty_i && (!cur_vld_q || (advance && last_run));

  always_comb begin
    step = StepFill;
    for (int i = NumSteps - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        step = 4'(i);
      end
    end
  end

  always_comb begin
    byte_d  = FillByte;
    len_d   = 8'd1;
    first_d = 1'b0;
    unique case (step)
      StepSync: begin
        byte_d  = SyncByte;
        first_d = 1'b1;
      end
      StepPidHi:   byte_d = (cur_q.pusi ? PusiFlag : 8'h00) | {3'b000, pid_i[12:8]};
      StepPidLo:   byte_d = pid_i[7:0];
      StepCc:      byte_d = (cur_q.adapt_en ? ScAfPayload : ScPayload) | {4'h0, cur_q.cc};
      StepAfLen:   byte_d = cur_q.adapt;
      StepAfFlags: byte_d = AfFlagsByte;
      StepStuff: begin
        byte_d = FillByte;
        len_d  = cur_q.adapt - 8'd1;
      end
      StepData:    byte_d = cur_q.data;
      StepFill: begin
        byte_d = FillByte;
        len_d  = cur_q.fill_len;
      end
      default: byte_d = FillByte;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_vld_q <= 1'b0;
      mask_q    <= '0;
    end else if (pop_o) begin
      cur_vld_q <= 1'b1;
      mask_q    <= head_mask;
    end else if (advance) begin
      mask_q <= rest;
      if (last_run) begin
        cur_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= q_head_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (runs_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      byte_q  <= byte_d;
      len_q   <= len_d;
      first_q <= first_d;
      plast_q <= last_run && cur_q.pkt_last;
      flast_q <= last_run && cur_q.frame_last;
      pkt_q   <= cur_q.pkt_total;
    end
  end

  assign runs_o.valid        = out_vld_q;
  assign runs_o.out_byte     = byte_q;
  assign runs_o.run_length   = len_q;
  assign runs_o.packet_first = first_q;
  assign runs_o.packet_last  = plast_q;
  assign runs_o.frame_last   = flast_q;
  assign runs_o.pkt_number   = pkt_q;

  a_sync_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && first_q |-> (byte_q == SyncByte) && (len_q == 8'd1) && !plast_q)
    else $error("packet start run malformed");

  a_frame_ends_packet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && flast_q |-> plast_q)
    else $error("frame end without packet end");

  a_run_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (len_q != 8'd0))
    else $error("zero-length run");

endmodule

>>> dv/ts_es_packetizer_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ts_es_packetizer_core_test
// Drives begin, header and stream items into the packetizer and checks every
// output run, in order, against a run-level model of the packet layout. It
// covers several PID settings, out-of-place bytes, abandoned frames, a long
// output stall and frames that end in short and minimal adaptation fields.
// ----------------------------------------------------------------------------
module ts_es_packetizer_core_test;
  import tsp_pkg::*;

  localparam logic [1:0] FuncVoid    = 2'd3;
  localparam logic [7:0] NoPusiFlags = 8'h00;
  localparam int unsigned HoldCycles   = 200;
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned RandomChunk  = 50;

  typedef struct packed {
    logic [1:0]  func;
    logic [3:0]  cc;
    logic        pusi;
    logic [7:0]  hlen;
    logic [19:0] elen;
    logic [7:0]  data;
  } es_item_t;

  typedef struct packed {
    logic [7:0]  value;
    logic [7:0]  len;
    logic        first;
    logic        last;
    logic        flast;
    logic [12:0] count;
  } byte_run_t;

  class run_scoreboard;
    logic [12:0] pid;
    logic [3:0]  cc;
    int unsigned es_left;
    int unsigned room;
    int unsigned hdr_left;
    bit          first_open;
    bit          active;
    logic [12:0] pkt_count;
    int unsigned step_base;
    int unsigned errors;
    byte_run_t   runs_due[$];

    function new();
      pid        = '0;
      cc         = '0;
      es_left    = 0;
      room       = 0;
      hdr_left   = 0;
      first_open = 1'b0;
      active     = 1'b0;
      pkt_count  = '0;
      errors     = 0;
    endfunction

    function void add_run(logic [7:0] v, logic [7:0] n, logic first);
      byte_run_t r;
      r.value = v;
      r.len   = n;
      r.first = first;
      r.last  = 1'b0;
      r.flast = 1'b0;
      r.count = pkt_count;
      runs_due.push_back(r);
    endfunction

    function void close_packet();
      byte_run_t r;
      room       = 0;
      first_open = 1'b0;
      if (runs_due.size() > step_base) begin
        r = runs_due.pop_back();
        r.last = 1'b1;
        if (es_left == 0 && hdr_left == 0) begin
          r.flast = 1'b1;
          active  = 1'b0;
        end
        runs_due.push_back(r);
      end
    endfunction

    function void open_packet(logic [7:0] b1, logic [7:0] b3);
      pkt_count = pkt_count + 13'd1;
      add_run(SyncByte, 8'd1, 1'b1);
      add_run(b1 | {3'b000, pid[12:8]}, 8'd1, 1'b0);
      add_run(pid[7:0], 8'd1, 1'b0);
      add_run(b3 | {4'b0000, cc}, 8'd1, 1'b0);
      cc = cc + 4'd1;
    endfunction

    function void fill_and_close();
      if (room > 0) add_run(FillByte, 8'(room), 1'b0);
      close_packet();
    endfunction

    function void note_item(es_item_t it);
      int unsigned hlen;
      int unsigned elen;
      int unsigned remaining;
      int unsigned adapt;
      step_base = runs_due.size();
      case (it.func)
        FuncBegin: begin
          hlen = it.hlen;
          elen = it.elen;
          if (hlen > PayloadBytes) hlen = PayloadBytes;
          if (elen > MaxFrameBytes) elen = MaxFrameBytes;
          cc         = it.cc;
          es_left    = elen;
          pkt_count  = '0;
          room       = 0;
          first_open = 1'b0;
          hdr_left   = 0;
          active     = 1'b1;
          if (it.pusi && hlen > 0) begin
            hdr_left   = hlen;
            first_open = 1'b1;
            room       = PayloadBytes;
            open_packet(PusiFlag, ScPayload);
          end else if (es_left == 0) begin
            active = 1'b0;
          end
        end
        FuncHdr: begin
          if (active && first_open && hdr_left > 0) begin
            add_run(it.data, 8'd1, 1'b0);
            hdr_left--;
            room--;
            if (hdr_left == 0) begin
              if (room == 0) close_packet();
              else if (es_left == 0) fill_and_close();
            end
          end
        end
        FuncEs: begin
          if (active && hdr_left == 0 && es_left > 0) begin
            if (!first_open && room == 0) begin
              remaining = es_left;
              if (remaining >= PayloadBytes) begin
                open_packet(NoPusiFlags, ScPayload);
                room = PayloadBytes;
              end else begin
                adapt = AdaptBase - remaining;
                open_packet(NoPusiFlags, ScAfPayload);
                add_run(8'(adapt), 8'd1, 1'b0);
                if (adapt >= 1) add_run(AfFlagsByte, 8'd1, 1'b0);
                if (adapt >= 2) add_run(FillByte, 8'(adapt - 1), 1'b0);
                room = remaining;
              end
            end
            add_run(it.data, 8'd1, 1'b0);
            room--;
            es_left--;
            if (room == 0) close_packet();
            else if (first_open && es_left == 0) fill_and_close();
          end
        end
        default: ;
      endcase
    endfunction

    function void check_run(byte_run_t got);
      byte_run_t want;
      if (runs_due.size() == 0) begin
        $error("unexpected run: out_byte %0h run_length %0d", got.value, got.len);
        errors++;
        return;
      end
      want = runs_due.pop_front();
      if (got.value !== want.value) begin
        $error("out_byte: expected %0h, got %0h", want.value, got.value);
        errors++;
      end
      if (got.len !== want.len) begin
        $error("run_length: expected %0d, got %0d", want.len, got.len);
        errors++;
      end
      if (got.first !== want.first) begin
        $error("packet_first: expected %0b, got %0b", want.first, got.first);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("packet_last: expected %0b, got %0b", want.last, got.last);
        errors++;
      end
      if (got.flast !== want.flast) begin
        $error("frame_last: expected %0b, got %0b", want.flast, got.flast);
        errors++;
      end
      if (got.count !== want.count) begin
        $error("pkt_number: expected %0d, got %0d", want.count, got.count);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PaddrW-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;
  logic steady = 1'b0;
  int unsigned stall_reqs = 0;
  int unsigned items_sent = 0;

  run_scoreboard sb = new();

  tsp_in_if  items ();
  tsp_out_if runs ();

  ts_es_packetizer_core u_top (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .items_i (items),
    .runs_o  (runs),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  // output side: random back-pressure plus one long hold on request
  initial begin
    int unsigned stall_seen;
    int unsigned hold_left;
    stall_seen = 0;
    hold_left  = 0;
    runs.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_reqs != stall_seen) begin
        stall_seen = stall_reqs;
        hold_left  = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        runs.ready <= 1'b0;
      end else begin
        runs.ready <= steady || ($urandom_range(99) >= 36);
      end
    end
  end

  always @(posedge clk) begin
    es_item_t  seen;
    byte_run_t got;
    if (rst_n && items.valid && items.ready) begin
      seen.func = items.func;
      seen.cc   = items.cc_init;
      seen.pusi = items.with_pusi;
      seen.hlen = items.header_length;
      seen.elen = items.es_length;
      seen.data = items.data_byte;
      sb.note_item(seen);
    end
    if (rst_n && runs.valid && runs.ready) begin
      got.value = runs.out_byte;
      got.len   = runs.run_length;
      got.first = runs.packet_first;
      got.last  = runs.packet_last;
      got.flast = runs.frame_last;
      got.count = runs.pkt_number;
      sb.check_run(got);
    end
  end

  task automatic push_item(input logic [1:0] f, input logic [3:0] c, input logic p,
                           input logic [7:0] h, input logic [19:0] e, input logic [7:0] d);
    if (!steady) begin
      while ($urandom_range(99) < 36) begin
        items.valid <= 1'b0;
        @(posedge clk);
      end
    end
    items.valid         <= 1'b1;
    items.func          <= f;
    items.cc_init       <= c;
    items.with_pusi     <= p;
    items.header_length <= h;
    items.es_length     <= e;
    items.data_byte     <= d;
    do @(posedge clk); while (!items.ready);
    items_sent++;
  endtask

  task automatic push_byte(input logic [1:0] f, input logic [7:0] d);
    push_item(f, 4'($urandom), 1'($urandom), 8'($urandom), 20'($urandom), d);
  endtask

  task automatic send_frame(input logic [3:0] c, input logic p, input logic [7:0] h,
                            input logic [19:0] e, input bit misplace);
    int unsigned hdr_n;
    hdr_n = 0;
    if (p && h != 0) hdr_n = (h > PayloadBytes) ? PayloadBytes : h;
    push_item(FuncBegin, c, p, h, e, 8'($urandom));
    if (misplace && hdr_n != 0) push_byte(FuncEs, 8'($urandom));
    repeat (hdr_n) push_byte(FuncHdr, 8'($urandom));
    repeat (e) push_byte(FuncEs, 8'($urandom));
  endtask

  task automatic random_frame();
    int unsigned kind;
    kind = $urandom_range(99);
    if (kind < 80) begin
      send_frame(4'($urandom), 1'($urandom), 8'($urandom_range(0, 12)),
                 20'($urandom_range(0, 40)), $urandom_range(9) == 0);
    end else if (kind < 90) begin
      // frame cut short; the next begin drops it
      push_item(FuncBegin, 4'($urandom), 1'($urandom), 8'($urandom), 20'($urandom),
                8'($urandom));
      repeat ($urandom_range(0, 5)) push_byte(2'($urandom_range(1, 2)), 8'($urandom));
    end else begin
      push_byte(2'($urandom_range(1, 3)), 8'($urandom));
    end
  endtask

  task automatic random_run(input int unsigned count);
    int unsigned goal;
    goal = items_sent + count;
    while (items_sent < goal) random_frame();
  endtask

  task automatic wait_idle();
    items.valid <= 1'b0;
    @(posedge clk);
    while (sb.runs_due.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_pid(input logic [12:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PaddrW'({RegStreamPid, 2'b00});
    pwdata  <= {19'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.pid = v;
  endtask

  initial begin
    rst_n               = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    items.valid         = 1'b0;
    items.func          = FuncBegin;
    items.cc_init       = '0;
    items.with_pusi     = 1'b0;
    items.header_length = '0;
    items.es_length     = '0;
    items.data_byte     = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_pid(13'h1FFF);
    // short PUSI frame with 0xFF fill, byte extremes
    push_item(FuncBegin, 4'd15, 1'b1, 8'd3, 20'd2, 8'h00);
    push_byte(FuncHdr, 8'h00);
    push_byte(FuncHdr, 8'hFF);
    push_byte(FuncHdr, 8'h47);
    push_byte(FuncEs, 8'hFF);
    push_byte(FuncEs, 8'h00);
    // bytes after the frame is complete, and the unused function
    push_byte(FuncHdr, 8'h5A);
    push_byte(FuncEs, 8'hA5);
    push_byte(FuncVoid, 8'h3C);
    // no PUSI packet: header byte ignored, short adaptation packet
    push_item(FuncBegin, 4'd0, 1'b0, 8'd7, 20'd3, 8'h00);
    push_byte(FuncHdr, 8'h11);
    push_byte(FuncEs, 8'h80);
    push_byte(FuncEs, 8'h7F);
    push_byte(FuncEs, 8'h01);
    // empty frame
    push_item(FuncBegin, 4'd5, 1'b0, 8'd0, 20'd0, 8'h00);
    push_byte(FuncEs, 8'h22);
    // oversized header length and maximum frame length, abandoned by the next begin
    push_item(FuncBegin, 4'd7, 1'b1, 8'd255, 20'hFFFFF, 8'h00);
    push_byte(FuncEs, 8'h33);
    push_byte(FuncHdr, 8'h44);
    push_byte(FuncHdr, 8'h55);
    // header only, rest of packet filled
    push_item(FuncBegin, 4'd10, 1'b1, 8'd2, 20'd0, 8'h00);
    push_byte(FuncHdr, 8'h66);
    push_byte(FuncHdr, 8'h77);
    wait_idle();

    // long output hold, then no idling on either side
    write_pid(13'h0000);
    steady     <= 1'b1;
    stall_reqs <= stall_reqs + 1;
    random_run(RandomChunk);
    wait_idle();
    steady <= 1'b0;

    write_pid(13'($urandom));
    random_run(RandomChunk);
    wait_idle();

    write_pid(13'($urandom_range(1, 8190)));
    random_run(RandomChunk);
    // one-byte and zero-length adaptation fields, each frame left open after
    // its first packet
    push_item(FuncBegin, 4'($urandom), 1'b0, 8'($urandom), 20'd182, 8'h00);
    push_byte(FuncEs, 8'($urandom));
    push_item(FuncBegin, 4'($urandom), 1'b0, 8'($urandom), 20'd183, 8'h00);
    push_byte(FuncEs, 8'($urandom));
    wait_idle();

    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> files.f
src/tsp_pkg.sv
src/tsp_if.sv
src/tsp_front.sv
src/tsp_cmd_fifo.sv
src/tsp_back.sv
src/ts_es_packetizer_core.sv
dv/ts_es_packetizer_core_test.sv
